// ===== rtl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants, opcodes and inter-stage words for the scaled tick timer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned MS_W        = 16;
    localparam int unsigned SCALE_W     = 32;
    localparam int unsigned PROD_W      = MS_W + SCALE_W;
    localparam int unsigned ACC_W       = 64;
    localparam int unsigned WHOLE_W     = 32;
    localparam int unsigned TICK_W      = 32;
    localparam int unsigned PROG_W      = 10;
    localparam int unsigned RSUM_W      = 12;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    // ms per tick and the reciprocal used for exact division of 32-bit values
    localparam int unsigned MS_PER_TICK = 1000;
    localparam int unsigned MAGIC_W     = 29;
    localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'h10624DD3;
    localparam int unsigned DIV_SHIFT   = 38;
    localparam int unsigned QM_W        = WHOLE_W + MAGIC_W;

    // a wrap of the 32-bit whole-ms field moves the residue by -2^32 mod 1000
    localparam int unsigned WRAP_ADJ =
        MS_PER_TICK - int'((64'd1 << WHOLE_W) % MS_PER_TICK);

    typedef enum logic [2:0] {
        OP_ELAPSE      = 3'd0,
        OP_START       = 3'd1,
        OP_PAUSE       = 3'd2,
        OP_TOGGLE      = 3'd3,
        OP_RESET       = 3'd4,
        OP_RESET_TICKS = 3'd5
    } opcode_t;

    // word handed from the front pipeline to the accumulator
    typedef struct packed {
        opcode_t             op;
        logic [PROD_W-1:0]   prod;
        logic [PROG_W-1:0]   dm;
    } stt_item_t;

    // word handed from the accumulator to the report stage
    typedef struct packed {
        logic [WHOLE_W-1:0]  whole_ms;
        logic [PROG_W-1:0]   rem;
        logic                run;
    } stt_tally_t;

endpackage

// ===== rtl/stt_front.sv =====
// ----------------------------------------------------------------------------
// stt_front
// Input register, scale multiply, and residue of the whole-ms delta mod 1000.
// ----------------------------------------------------------------------------
module stt_front
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SCALE_W-1:0]  scale,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [MS_W-1:0]     elapsed_ms,
    output logic                item_valid,
    input  logic                item_ready,
    output stt_item_t           item
);

    function automatic logic [WHOLE_W-1:0] prod_whole(input logic [PROD_W-1:0] p);
        logic [ACC_W-1:0] pe;
        pe = {{(ACC_W-PROD_W){1'b0}}, p};
        return pe[FRAC_BITS +: WHOLE_W];
    endfunction

    logic                a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic                a_ready, b_ready, c_ready, d_ready;

    opcode_t             a_op_reg, b_op_reg, c_op_reg, d_op_reg;
    logic [MS_W-1:0]     a_ms_reg;
    logic [PROD_W-1:0]   b_prod_reg, c_prod_reg, d_prod_reg;
    logic [QM_W-1:0]     c_qm_reg;
    logic [PROG_W-1:0]   d_dm_reg;

    logic [PROD_W-1:0]   b_prod_next;
    logic [QM_W-1:0]     c_qm_next;
    logic [PROG_W-1:0]   d_dm_next;
    logic [WHOLE_W-1:0]  c_whole, quot_times;

    // a stage takes a word when it is empty or its word moves on
    assign d_ready  = !d_v_reg || item_ready;
    assign c_ready  = !c_v_reg || d_ready;
    assign b_ready  = !b_v_reg || c_ready;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_ready = a_ready;

    assign b_prod_next = PROD_W'(a_ms_reg) * PROD_W'(scale);
    assign c_qm_next   = QM_W'(prod_whole(b_prod_reg)) * QM_W'(DIV_MAGIC);
    assign c_whole     = prod_whole(c_prod_reg);
    assign quot_times  = WHOLE_W'(c_qm_reg[QM_W-1:DIV_SHIFT]) * WHOLE_W'(MS_PER_TICK);
    assign d_dm_next   = PROG_W'(c_whole - quot_times);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else
        begin
            if (a_ready) a_v_reg <= in_valid;
            if (b_ready) b_v_reg <= a_v_reg;
            if (c_ready) c_v_reg <= b_v_reg;
            if (d_ready) d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_op_reg <= opcode_t'(opcode);
            a_ms_reg <= elapsed_ms;
        end
        if (a_v_reg && b_ready)
        begin
            b_op_reg   <= a_op_reg;
            b_prod_reg <= b_prod_next;
        end
        if (b_v_reg && c_ready)
        begin
            c_op_reg   <= b_op_reg;
            c_prod_reg <= b_prod_reg;
            c_qm_reg   <= c_qm_next;
        end
        if (c_v_reg && d_ready)
        begin
            d_op_reg   <= c_op_reg;
            d_prod_reg <= c_prod_reg;
            d_dm_reg   <= d_dm_next;
        end
    end

    assign item_valid = d_v_reg;
    assign item.op    = d_op_reg;
    assign item.prod  = d_prod_reg;
    assign item.dm    = d_dm_reg;

endmodule

// ===== rtl/stt_accum.sv =====
// ----------------------------------------------------------------------------
// stt_accum
// Fixed-point accumulator, running flag and whole-ms residue mod 1000.
// ----------------------------------------------------------------------------
module stt_accum
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  stt_item_t   item,
    output logic        tally_valid,
    input  logic        tally_ready,
    output stt_tally_t  tally
);

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [PROG_W-1:0]  rem_reg, rem_next;
    logic               run_reg, run_next;

    logic               e_v_reg;
    stt_tally_t         e_reg;
    logic               take;

    logic [ACC_W-1:0]   add, sum;
    logic [WHOLE_W-1:0] m_old, m_add, d_whole;
    logic [WHOLE_W:0]   t;
    logic               carry, wrap;
    logic [RSUM_W-1:0]  rsum;
    logic [PROG_W-1:0]  dm, rmod;

    assign item_ready = !e_v_reg || tally_ready;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        add     = run_reg ? {{(ACC_W-PROD_W){1'b0}}, item.prod} : '0;
        sum     = acc_reg + add;
        m_old   = acc_reg[FRAC_BITS +: WHOLE_W];
        m_add   = sum[FRAC_BITS +: WHOLE_W];
        d_whole = add[FRAC_BITS +: WHOLE_W];
        t       = {1'b0, m_old} + {1'b0, d_whole};
        // carry in from the fraction bits, and wrap of the whole-ms field
        carry   = (m_add != t[WHOLE_W-1:0]);
        wrap    = t[WHOLE_W] | (carry & (&t[WHOLE_W-1:0]));
        dm      = run_reg ? item.dm : '0;
        rsum    = RSUM_W'(rem_reg) + RSUM_W'(dm) + RSUM_W'(carry)
                + (wrap ? RSUM_W'(WRAP_ADJ) : '0);
        if (rsum >= RSUM_W'(2 * MS_PER_TICK))
            rmod = PROG_W'(rsum - RSUM_W'(2 * MS_PER_TICK));
        else if (rsum >= RSUM_W'(MS_PER_TICK))
            rmod = PROG_W'(rsum - RSUM_W'(MS_PER_TICK));
        else
            rmod = PROG_W'(rsum);

        acc_next = sum;
        rem_next = rmod;
        run_next = run_reg;
        unique case (item.op)
            OP_START:       run_next = 1'b1;
            OP_PAUSE:       run_next = 1'b0;
            OP_TOGGLE:      run_next = !run_reg;
            OP_RESET:
            begin
                acc_next = '0;
                rem_next = '0;
            end
            // keep only the part within the current tick
            OP_RESET_TICKS: acc_next[FRAC_BITS +: WHOLE_W] = WHOLE_W'(rmod);
            default:        run_next = run_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            run_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                run_reg <= run_next;
            end
            if (item_ready) e_v_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            e_reg.whole_ms <= acc_next[FRAC_BITS +: WHOLE_W];
            e_reg.rem      <= rem_next;
            e_reg.run      <= run_next;
        end
    end

    assign tally_valid = e_v_reg;
    assign tally       = e_reg;

`ifndef SYNTHESIS
    a_rem_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg == PROG_W'(acc_reg[FRAC_BITS +: WHOLE_W] % MS_PER_TICK))
        else $error("residue out of step with accumulator");

    a_reset_ticks_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.op == OP_RESET_TICKS) |=> e_reg.whole_ms == WHOLE_W'(e_reg.rem))
        else $error("reset_ticks left whole ticks behind");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> ($stable(acc_reg) && $stable(run_reg)))
        else $error("state changed without a word");
`endif

endmodule

// ===== rtl/stt_report.sv =====
// ----------------------------------------------------------------------------
// stt_report
// Tick quotient by reciprocal multiply, held in the result register.
// ----------------------------------------------------------------------------
module stt_report
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tally_valid,
    output logic                tally_ready,
    input  stt_tally_t          tally,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TICK_W-1:0]   tick_count,
    output logic [PROG_W-1:0]   progress_ms,
    output logic                due,
    output logic                running
);

    logic               v_reg;
    logic [QM_W-1:0]    qm_reg;
    logic [PROG_W-1:0]  rem_reg;
    logic               run_reg, due_reg;
    logic [QM_W-1:0]    qm_next;

    assign tally_ready = !v_reg || out_ready;
    assign qm_next     = QM_W'(tally.whole_ms) * QM_W'(DIV_MAGIC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (tally_ready)
            v_reg <= tally_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tally_valid && tally_ready)
        begin
            qm_reg  <= qm_next;
            rem_reg <= tally.rem;
            run_reg <= tally.run;
            due_reg <= (tally.whole_ms >= WHOLE_W'(MS_PER_TICK));
        end
    end

    assign out_valid   = v_reg;
    assign tick_count  = TICK_W'(qm_reg[QM_W-1:DIV_SHIFT]);
    assign progress_ms = rem_reg;
    assign due         = due_reg;
    assign running     = run_reg;

`ifndef SYNTHESIS
    a_due_matches_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg |-> (due == (tick_count != '0)))
        else $error("due flag disagrees with tick count");
`endif

endmodule

// ===== rtl/scaled_tick_timer_core.sv =====
// ----------------------------------------------------------------------------
// scaled_tick_timer_core
// A word passes front stages a-d, the accumulator and the result register.
// Throughput: one word per cycle unless out_ready stalls; the accumulator
// update is a registered loop and the multiplies sit in their own stages.
// Reset: accumulator zero, timer stopped, tick rate 65536, pipeline empty.
// ----------------------------------------------------------------------------
module scaled_tick_timer_core
    import stt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SCALE_W-1:0]  tick_rate,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [MS_W-1:0]     elapsed_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TICK_W-1:0]   tick_count,
    output logic [PROG_W-1:0]   progress_ms,
    output logic                due,
    output logic                running
);

    logic [SCALE_W-1:0] scale_reg;
    logic               item_valid, item_ready;
    stt_item_t          item;
    logic               tally_valid, tally_ready;
    stt_tally_t         tally;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= SCALE_RESET;
        else if (cfg_valid)
            scale_reg <= tick_rate;
    end

    stt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scale      (scale_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .elapsed_ms (elapsed_ms),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    stt_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .tally_valid (tally_valid),
        .tally_ready (tally_ready),
        .tally       (tally)
    );

    stt_report u_report (
        .clk         (clk),
        .rst_n       (rst_n),
        .tally_valid (tally_valid),
        .tally_ready (tally_ready),
        .tally       (tally),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tick_count  (tick_count),
        .progress_ms (progress_ms),
        .due         (due),
        .running     (running)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scaled tick timer core. A short directed plan
// covers the opcodes, the scale extremes and tick wrap, then random timer
// traffic under several scales. Every output word is checked against a typed
// reading or the bench's timer model, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import stt_pkg::*;
();

    typedef struct packed {
        logic [TICK_W-1:0]  ticks;
        logic [PROG_W-1:0]  prog;
        logic               due;
        logic               on;
    } tick_reading_t;

    typedef enum logic {ROW_WORD, ROW_SCALE} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         op;
        logic [MS_W-1:0]    ms;
        logic [SCALE_W-1:0] scale;
        logic               typed;
        tick_reading_t      want;
    } plan_row_t;

    // opcodes outside the enum, which the core runs as elapse
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 235;
    localparam int TAIL_CYCLES = 20;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [SCALE_W-1:0]  tick_rate;
    logic                in_valid;
    logic                in_ready;
    logic [2:0]          opcode;
    logic [MS_W-1:0]     elapsed_ms;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [TICK_W-1:0]   tick_count;
    logic [PROG_W-1:0]   progress_ms;
    logic                due;
    logic                running;

    // timer model state
    logic [ACC_W-1:0]    acc_fx;
    logic                timer_on;
    logic [SCALE_W-1:0]  scale_fx;

    tick_reading_t       pending_readings [$];
    plan_row_t           plan [$];
    int                  errors = 0;
    bit                  tx_calm = 1'b0;
    bit                  rx_calm = 1'b0;
    int                  rx_stall = 0;
    int                  rx_span = 0;

    scaled_tick_timer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .tick_rate   (tick_rate),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tick_count  (tick_count),
        .progress_ms (progress_ms),
        .due         (due),
        .running     (running)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // advance the timer by one word and return the reading it produces
    function automatic tick_reading_t advance_timer(logic [2:0] op, logic [MS_W-1:0] ms);
        tick_reading_t rd;
        logic [WHOLE_W-1:0] whole;
        logic [TICK_W-1:0]  whole_ticks;
        if (timer_on)
            acc_fx = acc_fx + ACC_W'(ms) * ACC_W'(scale_fx);
        case (op)
            OP_START:  timer_on = 1'b1;
            OP_PAUSE:  timer_on = 1'b0;
            OP_TOGGLE: timer_on = !timer_on;
            OP_RESET:  acc_fx = '0;
            OP_RESET_TICKS:
            begin
                whole       = acc_fx[FRAC_BITS +: WHOLE_W];
                whole_ticks = whole / MS_PER_TICK;
                acc_fx      = acc_fx - ((ACC_W'(whole_ticks) * MS_PER_TICK) << FRAC_BITS);
            end
            default: ;
        endcase
        whole    = acc_fx[FRAC_BITS +: WHOLE_W];
        rd.ticks = whole / MS_PER_TICK;
        rd.prog  = PROG_W'(whole % MS_PER_TICK);
        rd.due   = (rd.ticks != 0);
        rd.on    = timer_on;
        return rd;
    endfunction

    function automatic plan_row_t word_row(logic [2:0] op, logic [MS_W-1:0] ms);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_WORD;
        row.op    = op;
        row.ms    = ms;
        return row;
    endfunction

    function automatic plan_row_t typed_row(logic [2:0] op, logic [MS_W-1:0] ms,
                                            int unsigned ticks, int unsigned prog,
                                            bit d, bit on);
        plan_row_t row;
        row            = word_row(op, ms);
        row.typed      = 1'b1;
        row.want.ticks = ticks;
        row.want.prog  = PROG_W'(prog);
        row.want.due   = d;
        row.want.on    = on;
        return row;
    endfunction

    function automatic plan_row_t scale_row(logic [SCALE_W-1:0] value);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_SCALE;
        row.scale = value;
        return row;
    endfunction

    // hold the input side low until every pending word has come back
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_readings.size() != 0);
    endtask

    task automatic load_scale(logic [SCALE_W-1:0] value);
        hold_until_drained();
        cfg_valid <= 1'b1;
        tick_rate <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        scale_fx = value;
    endtask

    task automatic send_word(logic [2:0] op, logic [MS_W-1:0] ms, logic typed,
                             tick_reading_t want);
        int gap;
        tick_reading_t rd;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        elapsed_ms <= ms;
        do
            @(posedge clk);
        while (!in_ready);
        rd = advance_timer(op, ms);
        pending_readings.push_back(typed ? want : rd);
    endtask

    // output side: random stalls, check each accepted word
    always @(posedge clk)
    begin
        tick_reading_t exp_rd;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    report("output word with nothing pending");
                end
                else
                begin
                    exp_rd = pending_readings.pop_front();
                    if (tick_count !== exp_rd.ticks)
                        report($sformatf("tick_count got %0d expected %0d",
                                         tick_count, exp_rd.ticks));
                    if (progress_ms !== exp_rd.prog)
                        report($sformatf("progress_ms got %0d expected %0d",
                                         progress_ms, exp_rd.prog));
                    if (due !== exp_rd.due)
                        report($sformatf("due got %0b expected %0b", due, exp_rd.due));
                    if (running !== exp_rd.on)
                        report($sformatf("running got %0b expected %0b",
                                         running, exp_rd.on));
                end
            end
            if (rx_span == 0)
            begin
                rx_span = $urandom_range(50, 400);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            else
            begin
                rx_span--;
            end
            if (rx_stall > 0)
            begin
                out_ready <= 1'b0;
                rx_stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_stall = pick_gap(rx_calm);
            end
        end
    end

    initial
    begin
        int unsigned pick;
        logic [2:0] op;
        logic [MS_W-1:0] ms;
        logic [SCALE_W-1:0] scale;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        tick_rate  = '0;
        in_valid   = 1'b0;
        opcode     = '0;
        elapsed_ms = '0;
        acc_fx     = '0;
        timer_on   = 1'b0;
        scale_fx   = SCALE_RESET;

        // one tick per second at reset, so whole ms is the running sum of ms
        plan.push_back(typed_row(OP_ELAPSE,      16'd100,   0,   0, 0, 0));
        plan.push_back(typed_row(OP_PAUSE,       16'd5,     0,   0, 0, 0));
        plan.push_back(typed_row(OP_START,       16'hFFFF,  0,   0, 0, 1));
        plan.push_back(typed_row(OP_START,       16'd7,     0,   7, 0, 1));
        plan.push_back(typed_row(OP_ELAPSE,      16'd993,   1,   0, 1, 1));
        plan.push_back(typed_row(OP_ELAPSE,      16'hFFFF, 66, 535, 1, 1));
        plan.push_back(typed_row(OP_RESET_TICKS, 16'd0,     0, 535, 0, 1));
        plan.push_back(typed_row(OP_TOGGLE,      16'd465,   1,   0, 1, 0));
        plan.push_back(typed_row(OP_TOGGLE,      16'd300,   1,   0, 1, 1));
        plan.push_back(typed_row(OP_RESET,       16'd200,   0,   0, 0, 1));
        plan.push_back(typed_row(OP_SPARE_6,     16'd1,     0,   1, 0, 1));
        plan.push_back(typed_row(OP_SPARE_7,     16'd999,   1,   0, 1, 1));
        plan.push_back(typed_row(OP_PAUSE,       16'd0,     1,   0, 1, 0));
        plan.push_back(typed_row(OP_RESET,       16'd0,     0,   0, 0, 0));
        // zero scale: a running timer gains nothing
        plan.push_back(scale_row('0));
        plan.push_back(typed_row(OP_START,       16'd0,     0,   0, 0, 1));
        plan.push_back(typed_row(OP_ELAPSE,      16'hFFFF,  0,   0, 0, 1));
        // full scale: whole ms passes 32 bits within a few words
        plan.push_back(scale_row(SCALE_MAX));
        plan.push_back(word_row(OP_ELAPSE,       16'hFFFF));
        plan.push_back(word_row(OP_ELAPSE,       16'hFFFF));
        plan.push_back(word_row(OP_RESET_TICKS,  16'hFFFF));
        plan.push_back(scale_row(32'd1));
        plan.push_back(word_row(OP_ELAPSE,       16'hFFFF));
        plan.push_back(typed_row(OP_RESET,       16'hFFFF,  0,   0, 0, 1));
        plan.push_back(scale_row(32'h0001_8000));
        plan.push_back(word_row(OP_ELAPSE,       16'd1000));
        plan.push_back(word_row(OP_PAUSE,        16'd2000));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SCALE)
                load_scale(plan[i].scale);
            else
                send_word(plan[i].op, plan[i].ms, plan[i].typed, plan[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: scale = SCALE_RESET;
                1: scale = SCALE_MAX;
                2: scale = 32'd1;
                4: scale = SCALE_W'($urandom_range(1, 4096)) << FRAC_BITS;
                5: scale = $urandom_range(1, 200000);
                7: scale = 32'h000A_0000;
                default: scale = $urandom();
            endcase
            load_scale(scale);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 50 == 0)
                    tx_calm = ($urandom_range(0, 3) == 0);
                if ((phase == 0 && n == 100) || $urandom_range(0, 149) == 0)
                    hold_until_drained();

                // mostly elapse on a running timer, with commands mixed in
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    op = OP_ELAPSE;
                else if (pick < 64)
                    op = OP_START;
                else if (pick < 70)
                    op = OP_PAUSE;
                else if (pick < 77)
                    op = OP_TOGGLE;
                else if (pick < 81)
                    op = OP_RESET;
                else if (pick < 91)
                    op = OP_RESET_TICKS;
                else if (pick < 94)
                    op = OP_SPARE_6;
                else if (pick < 97)
                    op = OP_SPARE_7;
                else
                    op = OP_START;

                pick = $urandom_range(0, 9);
                if (pick == 0)
                    ms = '0;
                else if (pick == 1)
                    ms = '1;
                else if (pick < 6)
                    ms = MS_W'($urandom_range(0, 2000));
                else
                    ms = MS_W'($urandom_range(0, 65535));

                send_word(op, ms, 1'b0, '0);
            end
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== scaled_tick_timer_core.f =====
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_accum.sv
rtl/stt_report.sv
rtl/scaled_tick_timer_core.sv
sim/tb_top.sv
